// ----- rtl/core/hcow_pkg.sv -----
// shared types, tables and lookup functions for the hilbert child order walker
package hcow_pkg;

  localparam int CoordBits      = 32;
  localparam int LevelsPerStage = 4;
  localparam int NumWalkStages  = (CoordBits + LevelsPerStage - 1) / LevelsPerStage;
  localparam int DepthW         = 6;
  localparam int StateW         = 4;
  localparam int CodeW          = 3;
  localparam int NumStates3d    = 12;
  localparam int NumChildren    = 8;

  localparam logic [1:0] Dims1d = 2'd1;
  localparam logic [1:0] Dims2d = 2'd2;
  localparam logic [1:0] Dims3d = 2'd3;

  localparam logic [1:0] DimsReset = Dims3d;

  typedef struct packed {
    logic [31:0]       x_coord;
    logic [31:0]       y_coord;
    logic [31:0]       z_coord;
    logic [DepthW-1:0] depth;
  } in_t;

  typedef struct packed {
    logic [StateW-1:0] final_state;
    logic [CodeW-1:0]  child_at_0;
    logic [CodeW-1:0]  child_at_1;
    logic [CodeW-1:0]  child_at_2;
    logic [CodeW-1:0]  child_at_3;
    logic [CodeW-1:0]  child_at_4;
    logic [CodeW-1:0]  child_at_5;
    logic [CodeW-1:0]  child_at_6;
    logic [CodeW-1:0]  child_at_7;
  } out_t;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [DepthW-1:0]    remaining;
    logic [StateW-1:0]    state;
  } walk_t;

  typedef logic [NumChildren-1:0][CodeW-1:0] order_t;

  localparam logic [3:0] OctNext [12][8] = '{
    '{4'd8,  4'd4,  4'd3,  4'd4,  4'd10, 4'd5, 4'd3,  4'd5},
    '{4'd2,  4'd4,  4'd11, 4'd4,  4'd2,  4'd5, 4'd9,  4'd5},
    '{4'd1,  4'd7,  4'd8,  4'd8,  4'd1,  4'd6, 4'd10, 4'd10},
    '{4'd11, 4'd11, 4'd0,  4'd7,  4'd9,  4'd9, 4'd0,  4'd6},
    '{4'd8,  4'd0,  4'd11, 4'd1,  4'd6,  4'd0, 4'd6,  4'd1},
    '{4'd10, 4'd10, 4'd9,  4'd9,  4'd0,  4'd7, 4'd1,  4'd7},
    '{4'd10, 4'd10, 4'd9,  4'd9,  4'd4,  4'd2, 4'd4,  4'd3},
    '{4'd2,  4'd8,  4'd3,  4'd11, 4'd2,  4'd5, 4'd3,  4'd5},
    '{4'd0,  4'd2,  4'd9,  4'd9,  4'd4,  4'd7, 4'd4,  4'd7},
    '{4'd1,  4'd3,  4'd8,  4'd8,  4'd1,  4'd3, 4'd5,  4'd6},
    '{4'd11, 4'd11, 4'd0,  4'd2,  4'd5,  4'd6, 4'd0,  4'd2},
    '{4'd10, 4'd10, 4'd1,  4'd3,  4'd4,  4'd7, 4'd4,  4'd7}};

  localparam logic [2:0] OctRank [12][8] = '{
    '{3'd0, 3'd1, 3'd3, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5},
    '{3'd4, 3'd5, 3'd7, 3'd6, 3'd3, 3'd2, 3'd0, 3'd1},
    '{3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd0, 3'd2, 3'd1},
    '{3'd2, 3'd1, 3'd3, 3'd0, 3'd5, 3'd6, 3'd4, 3'd7},
    '{3'd0, 3'd1, 3'd7, 3'd6, 3'd3, 3'd2, 3'd4, 3'd5},
    '{3'd6, 3'd5, 3'd1, 3'd2, 3'd7, 3'd4, 3'd0, 3'd3},
    '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
    '{3'd6, 3'd7, 3'd1, 3'd0, 3'd5, 3'd4, 3'd2, 3'd3},
    '{3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5},
    '{3'd2, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd0, 3'd7},
    '{3'd4, 3'd3, 3'd5, 3'd2, 3'd7, 3'd0, 3'd6, 3'd1},
    '{3'd4, 3'd3, 3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1}};

  localparam logic [1:0] QuadNext [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd1},
    '{2'd2, 2'd1, 2'd2, 2'd3},
    '{2'd3, 2'd3, 2'd0, 2'd2}};

  localparam logic [1:0] QuadRank [4][4] = '{
    '{2'd0, 2'd1, 2'd3, 2'd2},
    '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd3, 2'd0}};

  function automatic logic [StateW-1:0] step_state(
    input logic [1:0]        dims,
    input logic [StateW-1:0] st,
    input logic [CodeW-1:0]  code
  );
    logic [StateW-1:0] nxt;
    nxt = '0;
    case (dims)
      Dims3d: begin
        if (st < StateW'(NumStates3d)) nxt = OctNext[st][code];
      end
      Dims2d: begin
        nxt = StateW'(QuadNext[st[1:0]][code[1:0]]);
      end
      default: begin
        nxt = '0;
      end
    endcase
    return nxt;
  endfunction

  function automatic order_t child_order(
    input logic [1:0]        dims,
    input logic [StateW-1:0] st
  );
    order_t ord;
    ord = '0;
    case (dims)
      Dims3d: begin
        if (st < StateW'(NumStates3d)) begin
          for (int i = 0; i < NumChildren; i++) begin
            ord[OctRank[st][i]] = CodeW'(i);
          end
        end
      end
      Dims2d: begin
        for (int i = 0; i < 4; i++) begin
          ord[CodeW'(QuadRank[st[1:0]][i])] = CodeW'(i);
        end
      end
      default: begin
        ord[0] = CodeW'(0);
        ord[1] = CodeW'(1);
      end
    endcase
    return ord;
  endfunction

endpackage

// ----- rtl/core/hilbert_child_order_walker.sv -----
// top level: hilbert state walk pipeline with child order output register
// pipeline: 8 walk stages of 4 levels each, then 1 order stage
// throughput: one beat per cycle while the output side does not stall
// each stage holds its beat under stall; a stage with no valid beat takes a new one
// reset clears all valid bits and sets dimensions to 3
module hilbert_child_order_walker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hcow_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hcow_pkg::out_t  out_data_o
);
  import hcow_pkg::*;

  logic [1:0] dims_q;

  logic  valid_s [NumWalkStages+1];
  logic  stall_s [NumWalkStages+1];
  walk_t data_s  [NumWalkStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DimsReset;
    end else if (cfg_we_i) begin
      dims_q <= cfg_data_i;
    end
  end

  // clamp depth to the coordinate width
  assign data_s[0] = '{
    x:         in_data_i.x_coord[CoordBits-1:0],
    y:         in_data_i.y_coord[CoordBits-1:0],
    z:         in_data_i.z_coord[CoordBits-1:0],
    remaining: (in_data_i.depth > DepthW'(CoordBits)) ? DepthW'(CoordBits) : in_data_i.depth,
    state:     StateW'(0)
  };

  assign valid_s[0]  = in_valid_i;
  assign in_stall_o  = stall_s[0];

  for (genvar k = 0; k < NumWalkStages; k++) begin : g_walk
    hcow_walk_stage u_walk (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .dims_i  (dims_q),
      .valid_i (valid_s[k]),
      .data_i  (data_s[k]),
      .stall_o (stall_s[k]),
      .valid_o (valid_s[k+1]),
      .data_o  (data_s[k+1]),
      .stall_i (stall_s[k+1])
    );
  end

  hcow_order_stage u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dims_i  (dims_q),
    .valid_i (valid_s[NumWalkStages]),
    .data_i  (data_s[NumWalkStages]),
    .stall_o (stall_s[NumWalkStages]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o),
    .stall_i (out_stall_i)
  );

endmodule

// ----- rtl/core/hcow_walk_stage.sv -----
// one pipeline stage that steps the hilbert state over a group of bit levels
module hcow_walk_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    dims_i,
  input  logic          valid_i,
  input  hcow_pkg::walk_t data_i,
  output logic          stall_o,
  output logic          valid_o,
  output hcow_pkg::walk_t data_o,
  input  logic          stall_i
);
  import hcow_pkg::*;

  logic  valid_q;
  walk_t data_q;
  walk_t data_d;

  assign stall_o = valid_q & stall_i;

  always_comb begin
    logic [StateW-1:0] st;
    logic [CodeW-1:0]  code;
    st = data_i.state;
    for (int j = 0; j < LevelsPerStage; j++) begin
      code = {data_i.z[CoordBits-1-j], data_i.y[CoordBits-1-j], data_i.x[CoordBits-1-j]};
      if (DepthW'(j) < data_i.remaining) st = step_state(dims_i, st, code);
    end
    data_d.state = st;
    data_d.x     = data_i.x << LevelsPerStage;
    data_d.y     = data_i.y << LevelsPerStage;
    data_d.z     = data_i.z << LevelsPerStage;
    data_d.remaining = (data_i.remaining > DepthW'(LevelsPerStage)) ?
                       data_i.remaining - DepthW'(LevelsPerStage) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/hcow_order_stage.sv -----
// output stage that turns the final state into the child visiting order
module hcow_order_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      dims_i,
  input  logic            valid_i,
  input  hcow_pkg::walk_t data_i,
  output logic            stall_o,
  output logic            valid_o,
  output hcow_pkg::out_t  data_o,
  input  logic            stall_i
);
  import hcow_pkg::*;

  logic   valid_q;
  out_t   data_q;
  out_t   data_d;
  order_t ord;

  assign stall_o = valid_q & stall_i;
  assign ord     = child_order(dims_i, data_i.state);

  always_comb begin
    data_d.final_state = data_i.state;
    data_d.child_at_0  = ord[0];
    data_d.child_at_1  = ord[1];
    data_d.child_at_2  = ord[2];
    data_d.child_at_3  = ord[3];
    data_d.child_at_4  = ord[4];
    data_d.child_at_5  = ord[5];
    data_d.child_at_6  = ord[6];
    data_d.child_at_7  = ord[7];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/hcow_checker.sv -----
// port level checker for the hilbert child order walker, bound to the top level
module hcow_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_data_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  hcow_pkg::out_t out_data_o
);
  import hcow_pkg::*;

  logic [1:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DimsReset;
    end else if (cfg_we_i) begin
      dims_q <= cfg_data_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed under stall");

  a_one_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dims_q != Dims2d && dims_q != Dims3d |->
      out_data_o.final_state == '0 && out_data_o.child_at_0 == CodeW'(0) &&
      out_data_o.child_at_1 == CodeW'(1) && out_data_o.child_at_2 == '0 &&
      out_data_o.child_at_7 == '0)
    else $error("bad 1d result");

  a_two_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dims_q == Dims2d |->
      out_data_o.final_state < StateW'(4) && out_data_o.child_at_4 == '0 &&
      out_data_o.child_at_5 == '0 && out_data_o.child_at_6 == '0 &&
      out_data_o.child_at_7 == '0)
    else $error("bad 2d result");

  a_three_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dims_q == Dims3d |->
      out_data_o.final_state < StateW'(NumStates3d) &&
      out_data_o.child_at_0 != out_data_o.child_at_7)
    else $error("bad 3d result");

endmodule

bind hilbert_child_order_walker hcow_checker u_hcow_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb.sv -----
// testbench for the hilbert child order walker: directed table, random phases, predictor check
`timescale 1ns / 100ps

module tb;
  import hcow_pkg::*;

  localparam logic [1:0] DimsNone = 2'd0;
  localparam int HoldCycles  = 60;
  localparam int SettleCycles = 12;
  localparam int QuietLimit  = 2000;
  localparam int NumProbes   = 22;
  localparam int NumPhases   = 7;

  localparam logic [3:0] OctStep [12][8] = '{
    '{4'd8,  4'd4,  4'd3,  4'd4,  4'd10, 4'd5, 4'd3,  4'd5},
    '{4'd2,  4'd4,  4'd11, 4'd4,  4'd2,  4'd5, 4'd9,  4'd5},
    '{4'd1,  4'd7,  4'd8,  4'd8,  4'd1,  4'd6, 4'd10, 4'd10},
    '{4'd11, 4'd11, 4'd0,  4'd7,  4'd9,  4'd9, 4'd0,  4'd6},
    '{4'd8,  4'd0,  4'd11, 4'd1,  4'd6,  4'd0, 4'd6,  4'd1},
    '{4'd10, 4'd10, 4'd9,  4'd9,  4'd0,  4'd7, 4'd1,  4'd7},
    '{4'd10, 4'd10, 4'd9,  4'd9,  4'd4,  4'd2, 4'd4,  4'd3},
    '{4'd2,  4'd8,  4'd3,  4'd11, 4'd2,  4'd5, 4'd3,  4'd5},
    '{4'd0,  4'd2,  4'd9,  4'd9,  4'd4,  4'd7, 4'd4,  4'd7},
    '{4'd1,  4'd3,  4'd8,  4'd8,  4'd1,  4'd3, 4'd5,  4'd6},
    '{4'd11, 4'd11, 4'd0,  4'd2,  4'd5,  4'd6, 4'd0,  4'd2},
    '{4'd10, 4'd10, 4'd1,  4'd3,  4'd4,  4'd7, 4'd4,  4'd7}};

  localparam logic [3:0] OctPos [12][8] = '{
    '{4'd0, 4'd1, 4'd3, 4'd2, 4'd7, 4'd6, 4'd4, 4'd5},
    '{4'd4, 4'd5, 4'd7, 4'd6, 4'd3, 4'd2, 4'd0, 4'd1},
    '{4'd4, 4'd7, 4'd5, 4'd6, 4'd3, 4'd0, 4'd2, 4'd1},
    '{4'd2, 4'd1, 4'd3, 4'd0, 4'd5, 4'd6, 4'd4, 4'd7},
    '{4'd0, 4'd1, 4'd7, 4'd6, 4'd3, 4'd2, 4'd4, 4'd5},
    '{4'd6, 4'd5, 4'd1, 4'd2, 4'd7, 4'd4, 4'd0, 4'd3},
    '{4'd2, 4'd1, 4'd5, 4'd6, 4'd3, 4'd0, 4'd4, 4'd7},
    '{4'd6, 4'd7, 4'd1, 4'd0, 4'd5, 4'd4, 4'd2, 4'd3},
    '{4'd0, 4'd7, 4'd3, 4'd4, 4'd1, 4'd6, 4'd2, 4'd5},
    '{4'd2, 4'd5, 4'd3, 4'd4, 4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd4, 4'd3, 4'd5, 4'd2, 4'd7, 4'd0, 4'd6, 4'd1},
    '{4'd4, 4'd3, 4'd7, 4'd0, 4'd5, 4'd2, 4'd6, 4'd1}};

  localparam logic [3:0] QuadStep [4][4] = '{
    '{4'd1, 4'd0, 4'd3, 4'd0},
    '{4'd0, 4'd2, 4'd1, 4'd1},
    '{4'd2, 4'd1, 4'd2, 4'd3},
    '{4'd3, 4'd3, 4'd0, 4'd2}};

  localparam logic [3:0] QuadPos [4][4] = '{
    '{4'd0, 4'd1, 4'd3, 4'd2},
    '{4'd0, 4'd3, 4'd1, 4'd2},
    '{4'd2, 4'd3, 4'd1, 4'd0},
    '{4'd2, 4'd1, 4'd3, 4'd0}};

  localparam out_t NoOrder     = '0;
  localparam out_t Order3dRoot = {4'd0, 3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4};
  localparam out_t Order2dRoot = {4'd0, 3'd0, 3'd1, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0};
  localparam out_t Order1d     = {4'd0, 3'd0, 3'd1, 18'd0};

  typedef struct packed {
    logic [1:0]  dims;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  depth;
    logic        typed;
    out_t        result;
  } probe_t;

  probe_t probes [NumProbes] = '{
    {Dims3d, 32'h00000000, 32'h00000000, 32'h00000000, 6'd0,  1'b1, Order3dRoot},
    {Dims3d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd0,  1'b1, Order3dRoot},
    {Dims3d, 32'h00000000, 32'h00000000, 32'h00000000, 6'd1,  1'b0, NoOrder},
    {Dims3d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd32, 1'b0, NoOrder},
    {Dims3d, 32'h00000000, 32'h00000000, 32'h00000000, 6'd32, 1'b0, NoOrder},
    {Dims3d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd33, 1'b0, NoOrder},
    {Dims3d, 32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 6'd63, 1'b0, NoOrder},
    {Dims3d, 32'h00000001, 32'h00000000, 32'h00000000, 6'd31, 1'b0, NoOrder},
    {Dims3d, 32'h80000000, 32'h00000000, 32'h00000000, 6'd1,  1'b0, NoOrder},
    {Dims3d, 32'h00000000, 32'h40000000, 32'hc0000000, 6'd2,  1'b0, NoOrder},
    {Dims3d, 32'h9e3779b9, 32'h7f4a7c15, 32'h2545f491, 6'd8,  1'b0, NoOrder},
    {Dims2d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd0,  1'b1, Order2dRoot},
    {Dims2d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd32, 1'b0, NoOrder},
    {Dims2d, 32'h12345678, 32'h9abcdef0, 32'hffffffff, 6'd16, 1'b0, NoOrder},
    {Dims2d, 32'h00000000, 32'hffffffff, 32'h00000000, 6'd63, 1'b0, NoOrder},
    {Dims2d, 32'h80000000, 32'h40000000, 32'h00000000, 6'd2,  1'b0, NoOrder},
    {Dims1d, 32'h00000000, 32'h00000000, 32'h00000000, 6'd0,  1'b1, Order1d},
    {Dims1d, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'd63, 1'b1, Order1d},
    {Dims1d, 32'hdeadbeef, 32'h0badf00d, 32'h13579bdf, 6'd5,  1'b1, Order1d},
    {DimsNone, 32'hffffffff, 32'h00000000, 32'hffffffff, 6'd32, 1'b1, Order1d},
    {DimsNone, 32'h00000000, 32'h00000000, 32'h00000000, 6'd0, 1'b1, Order1d},
    {Dims3d, 32'hc3a5e1f0, 32'h0f1e2d3c, 32'h8badf00d, 6'd12, 1'b0, NoOrder}};

  localparam logic [1:0] PhaseDims [NumPhases] = '{
    Dims3d, Dims2d, DimsNone, Dims1d, Dims3d, Dims2d, Dims3d};
  localparam int PhaseItems [NumPhases] = '{300, 200, 80, 80, 300, 140, 200};

  logic  clk_i;
  logic  rst_ni;
  logic  cfg_we_i;
  logic  [1:0] cfg_data_i;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_data_o;

  out_t       child_orders_due [$];
  logic [1:0] dims_now;
  bit         idle_on;
  bit         hold_req;
  int         mismatches;
  int         quiet_cycles;

  hilbert_child_order_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic out_t walk_children(in_t beat, logic [1:0] dims);
    logic [3:0] st;
    logic [2:0] code;
    logic [2:0] order [8];
    int         levels;
    int         pos;
    out_t       r;
    st = '0;
    levels = (beat.depth > CoordBits) ? CoordBits : int'(beat.depth);
    for (int lvl = 0; lvl < levels; lvl++) begin
      pos = CoordBits - 1 - lvl;
      code = {beat.z_coord[pos], beat.y_coord[pos], beat.x_coord[pos]};
      if (dims == Dims3d) begin
        st = OctStep[st][code];
      end else if (dims == Dims2d) begin
        st = QuadStep[st[1:0]][code[1:0]];
      end else begin
        st = '0;
      end
    end
    for (int k = 0; k < 8; k++) order[k] = 3'd0;
    if (dims == Dims3d) begin
      for (int k = 0; k < 8; k++) order[OctPos[st][k][2:0]] = 3'(k);
    end else if (dims == Dims2d) begin
      for (int k = 0; k < 4; k++) order[QuadPos[st[1:0]][k][1:0]] = 3'(k);
    end else begin
      order[1] = 3'd1;
    end
    r.final_state = st;
    r.child_at_0 = order[0];
    r.child_at_1 = order[1];
    r.child_at_2 = order[2];
    r.child_at_3 = order[3];
    r.child_at_4 = order[4];
    r.child_at_5 = order[5];
    r.child_at_6 = order[6];
    r.child_at_7 = order[7];
    return r;
  endfunction

  function automatic string show_order(out_t r);
    return $sformatf("state %0d children %0d %0d %0d %0d %0d %0d %0d %0d", r.final_state,
                     r.child_at_0, r.child_at_1, r.child_at_2, r.child_at_3,
                     r.child_at_4, r.child_at_5, r.child_at_6, r.child_at_7);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // holds valid after acceptance so back-to-back beats need no second assignment
  task automatic offer_beat(in_t beat, bit typed, out_t typed_order);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    child_orders_due.push_back(typed ? typed_order : walk_children(beat, dims_now));
  endtask

  task automatic write_dims(logic [1:0] dims);
    in_valid_i <= 1'b0;
    while (child_orders_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= dims;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dims_now = dims;
  endtask

  // receiver side
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (child_orders_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %s", show_order(out_data_o));
      end else begin
        want = child_orders_due.pop_front();
        if (want.final_state !== out_data_o.final_state ||
            want.child_at_0 !== out_data_o.child_at_0 ||
            want.child_at_1 !== out_data_o.child_at_1 ||
            want.child_at_2 !== out_data_o.child_at_2 ||
            want.child_at_3 !== out_data_o.child_at_3 ||
            want.child_at_4 !== out_data_o.child_at_4 ||
            want.child_at_5 !== out_data_o.child_at_5 ||
            want.child_at_6 !== out_data_o.child_at_6 ||
            want.child_at_7 !== out_data_o.child_at_7) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp %s", show_order(want));
            $display("  got %s", show_order(out_data_o));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_t beat;
    probe_t row;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    dims_now     = DimsReset;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= Dims3d;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumProbes; p++) begin
      row = probes[p];
      if (row.dims != dims_now) write_dims(row.dims);
      beat.x_coord = row.x;
      beat.y_coord = row.y;
      beat.z_coord = row.z;
      beat.depth   = row.depth;
      offer_beat(beat, row.typed, row.result);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_dims(PhaseDims[ph]);
      idle_on = (ph != 4);
      for (int n = 0; n < PhaseItems[ph]; n++) begin
        if ((ph == 0 || ph == 5) && n == 60) hold_req = 1'b1;
        beat.x_coord = pick_coord();
        beat.y_coord = pick_coord();
        beat.z_coord = pick_coord();
        beat.depth   = ($urandom_range(99) < 8) ? 6'($urandom_range(63, 33))
                                                : 6'($urandom_range(32, 0));
        offer_beat(beat, 1'b0, NoOrder);
      end
    end

    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (child_orders_due.size() != 0) @(posedge clk_i);
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
